@@ sv/btd_pkg.sv @@
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types and constants for the binary to decimal digit emitter.
// ----------------------------------------------------------------------------
package btd_pkg;

  localparam int IN_W        = 31;
  localparam int DIGIT_W     = 4;
  localparam int STEP_BITS   = 4;
  localparam int CONV_CYCLES = (IN_W + STEP_BITS - 1) / STEP_BITS;
  localparam int BIN_W       = CONV_CYCLES * STEP_BITS;
  localparam int CNT_W       = (CONV_CYCLES > 1) ? $clog2(CONV_CYCLES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ sv/btd_cell.sv @@
// ----------------------------------------------------------------------------
// btd_cell
// One BCD digit of the shift-and-add-3 chain; STEP_BITS bits a shift cycle.
// ----------------------------------------------------------------------------
module btd_cell (
  input  logic                              clk,
  input  btd_pkg::cell_ctrl_t               ctrl,
  input  logic [btd_pkg::STEP_BITS-1:0]     cin,
  output logic [btd_pkg::STEP_BITS-1:0]     cout,
  output logic [btd_pkg::DIGIT_W-1:0]       digit
);
  import btd_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] shifted;

  // Highest carry bit is the first step of the cycle.
  always_comb begin
    logic [DIGIT_W-1:0] d;
    d = digit_r;
    for (int s = STEP_BITS - 1; s >= 0; s--) begin
      if (d >= DIGIT_W'(5)) begin
        d = d + DIGIT_W'(3);
      end
      cout[s] = d[DIGIT_W-1];
      d = {d[DIGIT_W-2:0], cin[s]};
    end
    shifted = d;
  end

  always_comb begin
    priority if (ctrl.load) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = shifted;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

@@ sv/binary_to_decimal_digit_emitter.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_emitter
// Splits a binary integer into decimal digits, most significant first.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_value, in_final_number
//  out     | output    | out_valid, out_stall, out_digit, out_last_digit,
//          |           | out_end_of_list
//
//  An item is loaded, makes eight passes of four bits through the digit cell
//  chain, has its leading digit found, then passes its digits one at a time
//  out of the output register. The input stalls until the sequencer idles.
//  Synchronous active-low reset returns the sequencer to idle and empties the
//  output register. A stalled output holds the digit and pauses the sequence.
//  Numbers wider than MAX_DIGITS digits emit no transfer.
// ----------------------------------------------------------------------------
module binary_to_decimal_digit_emitter #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [btd_pkg::IN_W-1:0]      in_value,
  input  logic                          in_final_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [btd_pkg::DIGIT_W-1:0]   out_digit,
  output logic                          out_last_digit,
  output logic                          out_end_of_list
);
  import btd_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  state_t             state_r, state_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               fin_r, fin_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0] out_digit_r, out_digit_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_eol_r, out_eol_nxt;

  cell_ctrl_t         ctrl;
  logic [STEP_BITS-1:0] carry [MAX_DIGITS+1];
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [IDX_W-1:0]   msd;
  logic               in_xfer;
  logic               out_free;

  assign carry[0] = bin_r[BIN_W-1 -: STEP_BITS];

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    btd_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .cin   (carry[g]),
      .cout  (carry[g+1]),
      .digit (digits[g])
    );
  end

  always_comb begin
    msd = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits[i] != '0) begin
        msd = IDX_W'(i);
      end
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    out_eol_nxt   = out_eol_r;
    ctrl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          bin_nxt   = BIN_W'(in_value);
          fin_nxt   = in_final_number;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          ctrl.load = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.shift = 1'b1;
        bin_nxt    = bin_r << STEP_BITS;
        ovf_nxt    = ovf_r || (carry[MAX_DIGITS] != '0);
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CONV_CYCLES - 1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt   = msd;
        state_nxt = ovf_r ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = digits[idx_r];
          out_last_nxt  = (idx_r == '0);
          out_eol_nxt   = (idx_r == '0) && fin_r;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    cnt_r       <= cnt_nxt;
    ovf_r       <= ovf_nxt;
    fin_r       <= fin_nxt;
    idx_r       <= idx_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
    out_eol_r   <= out_eol_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digit       = out_digit_r;
  assign out_last_digit  = out_last_r;
  assign out_end_of_list = out_eol_r;

`ifndef NO_ASSERTIONS
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_digit_r <= DIGIT_W'(9)))
    else $error("digit out of decimal range");

  a_eol_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eol_r |-> out_last_r)
    else $error("end of list away from last digit");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CONV))
    else $error("transfer in did not start conversion");

  a_no_emit_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !ovf_r)
    else $error("emitting a number that overflowed the chain");
`endif

endmodule
